// ===== hdl/bfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bitmap font character renderer.
package bfr_pkg;

	localparam int ADDR_W     = 14;
	localparam int PIX_W      = 8;
	localparam int CODE_W     = 8;
	localparam int FIDX_W     = 10;
	localparam int GLYPH_W    = 7;
	localparam int PIX_CNT_W  = 6;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	localparam logic [CODE_W-1:0] CODE_CR = 8'd13;
	localparam logic [CODE_W-1:0] CODE_LF = 8'd10;
	localparam logic [CODE_W-1:0] FIRST_PRINTABLE = 8'd32;

	localparam logic [PIX_W-1:0] PIX_ON  = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_OFF = 8'h00;

	typedef enum logic {
		OP_FONT = 1'b0,
		OP_CHAR = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_RUN
	} seq_state_t;

	// Operations of the shared address adder
	typedef enum logic [2:0] {
		AOP_NOP,
		AOP_START,
		AOP_PIX,
		AOP_LINE,
		AOP_NEXT_ROW,
		AOP_HOME_ROW
	} addr_op_t;

	typedef struct packed {
		logic              emit;
		logic [PIX_W-1:0]  value;
		logic              last;
	} pix_emit_t;

endpackage

// ===== hdl/bitmap_font_char_renderer.sv =====
`timescale 1ns / 1ps
// Top level of the 8x8 bitmap font character renderer.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser opcode; tdata font_index, font_byte, char_code
// m_*       out  m_tvalid/m_tready  tdata pixel_address, pixel_value; tlast last_pixel
//
// A font write or a control code completes in the cycle it is accepted. A printable
// character is accepted, then ST_START fetches glyph row 0 and sets up the address,
// then 64 pixel transactions follow, one per cycle while the output slot is free,
// set by the single address adder and the one read port of the font RAM.
// arst_n clears the cursor, sequencer and output valid; the font store holds
// no reset and is undefined until written.
module bitmap_font_char_renderer import bfr_pkg::*; #(
	parameter int COLUMNS     = 20,
	parameter int ROWS        = 12,
	parameter int LINE_STRIDE = 160,
	parameter int GLYPH_COUNT = 96
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // font_index[9:0], font_byte[17:10], char_code[25:18]
	input  logic                  s_tuser,  // opcode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // pixel_address[13:0], pixel_value[21:14]
	output logic                  m_tlast   // last_pixel
);

	// cursor widths; a single column or row still needs one bit
	localparam int CW         = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int STORE_SIZE = GLYPH_COUNT * 8;
	localparam int AW         = $clog2(STORE_SIZE);

	logic [FIDX_W-1:0]      font_index;
	logic [PIX_W-1:0]       font_byte;
	logic [CODE_W-1:0]      char_code;
	opcode_t                opcode;
	logic                   ready;
	logic                   font_we;
	logic [11:0]            widx;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [PIX_W-1:0]       font_row;
	addr_op_t               aop;
	logic [CW-1:0]          col;
	logic [ADDR_W-1:0]      pix_addr;
	pix_emit_t              pix;
	logic                   slot_free;
	logic                   m_valid_q;
	logic [OUT_DATA_W-1:0]  m_data_q;
	logic                   m_last_q;

	assign font_index = s_tdata[9:0];
	assign font_byte  = s_tdata[17:10];
	assign char_code  = s_tdata[25:18];
	assign opcode     = opcode_t'(s_tuser);

	// font writes beyond the store are dropped
	assign widx    = {2'b00, font_index};
	assign font_we = s_tvalid && ready && (opcode == OP_FONT)
	                 && (widx < 12'(STORE_SIZE));

	bfr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_SIZE)
	) u_font (
		.clk   (clk),
		.we    (font_we),
		.waddr (widx[AW-1:0]),
		.wdata (font_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (font_row)
	);

	bfr_seq #(
		.COLUMNS     (COLUMNS),
		.ROWS        (ROWS),
		.GLYPH_COUNT (GLYPH_COUNT),
		.CW          (CW),
		.RW          (RW),
		.AW          (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.opcode    (opcode),
		.char_code (char_code),
		.slot_free (slot_free),
		.font_row  (font_row),
		.ready     (ready),
		.aop       (aop),
		.col       (col),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.pix       (pix)
	);

	bfr_addr #(
		.LINE_STRIDE (LINE_STRIDE),
		.CW          (CW)
	) u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (aop),
		.col    (col),
		.addr   (pix_addr)
	);

	// output register: a new pixel enters when the slot is empty or draining
	assign slot_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pix.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.emit) begin
			m_data_q <= {2'b00, pix.value, pix_addr};
			m_last_q <= pix.last;
		end
	end

	assign s_tready = ready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== hdl/bfr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/bfr_addr.sv =====
`timescale 1ns / 1ps
// Shared address adder: pixel address accumulator and text-row base register.
module bfr_addr import bfr_pkg::*; #(
	parameter int LINE_STRIDE = 160,
	parameter int CW          = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  addr_op_t          op,
	input  logic [CW-1:0]     col,
	output logic [ADDR_W-1:0] addr
);

	// step from the last pixel of a glyph row to the first of the next
	localparam logic [ADDR_W-1:0] LINE_ADV = ADDR_W'(LINE_STRIDE - 7);
	// one text row is eight scan lines
	localparam logic [ADDR_W-1:0] ROW_ADV  = ADDR_W'(LINE_STRIDE * 8);

	logic [ADDR_W-1:0] acc_q;
	logic [ADDR_W-1:0] rbase_q;
	logic [ADDR_W-1:0] opa;
	logic [ADDR_W-1:0] opb;
	logic [ADDR_W-1:0] sum;

	always_comb begin
		opa = acc_q;
		opb = '0;
		unique case (op)
			AOP_START: begin
				opa = rbase_q;
				opb = ADDR_W'({col, 3'b000});
			end
			AOP_PIX: begin
				opb = ADDR_W'(1);
			end
			AOP_LINE: begin
				opb = LINE_ADV;
			end
			AOP_NEXT_ROW: begin
				opa = rbase_q;
				opb = ROW_ADV;
			end
			AOP_NOP, AOP_HOME_ROW: begin
				opb = '0;
			end
			default: begin
				opb = '0;
			end
		endcase
	end

	assign sum = opa + opb;

	always_ff @(posedge clk) begin
		if (op == AOP_START || op == AOP_PIX || op == AOP_LINE) begin
			acc_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbase_q <= '0;
		end else if (op == AOP_NEXT_ROW) begin
			rbase_q <= sum;
		end else if (op == AOP_HOME_ROW) begin
			rbase_q <= '0;
		end
	end

	assign addr = acc_q;

endmodule

// ===== hdl/bfr_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: command decode, cursor, glyph fetch and pixel walk.
module bfr_seq import bfr_pkg::*; #(
	parameter int COLUMNS     = 20,
	parameter int ROWS        = 12,
	parameter int GLYPH_COUNT = 96,
	parameter int CW          = 5,
	parameter int RW          = 4,
	parameter int AW          = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  opcode_t           opcode,
	input  logic [CODE_W-1:0] char_code,
	input  logic              slot_free,
	input  logic [PIX_W-1:0]  font_row,
	output logic              ready,
	output addr_op_t          aop,
	output logic [CW-1:0]     col,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	output pix_emit_t         pix
);

	localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

	seq_state_t             state_q;
	seq_state_t             state_d;
	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic [GLYPH_W-1:0]     glyph_q;
	logic                   oob_q;
	logic [PIX_CNT_W-1:0]   cnt_q;
	logic                   accept;
	logic                   is_char;
	logic                   printable;
	logic                   emit;
	logic                   last;
	logic [2:0]             gl_row;
	logic [2:0]             gl_col;
	logic [2:0]             rd_row;
	logic [11:0]            rd_wide;
	logic [GLYPH_W-1:0]     glyph_in;
	addr_op_t               row_op;

	assign accept    = in_valid && ready;
	assign is_char   = accept && (opcode == OP_CHAR);
	assign printable = !char_code[7] && (char_code[6:5] != 2'b00);
	assign glyph_in  = char_code[GLYPH_W-1:0] - FIRST_PRINTABLE[GLYPH_W-1:0];
	assign gl_row    = cnt_q[5:3];
	assign gl_col    = cnt_q[2:0];
	assign emit      = (state_q == ST_RUN) && slot_free;
	assign last      = (cnt_q == '1);
	assign row_op    = (row_q == ROW_LAST) ? AOP_HOME_ROW : AOP_NEXT_ROW;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_char && printable) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (emit && last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		aop    = AOP_NOP;
		rd_en  = 1'b0;
		rd_row = 3'd0;
		unique case (state_q)
			ST_IDLE: begin
				if (is_char && char_code == CODE_LF) begin
					aop = row_op;
				end
			end
			ST_START: begin
				aop   = AOP_START;
				rd_en = 1'b1;
			end
			ST_RUN: begin
				if (emit) begin
					if (last) begin
						aop = (col_q == COL_LAST) ? row_op : AOP_NOP;
					end else if (gl_col == 3'd7) begin
						aop    = AOP_LINE;
						rd_en  = 1'b1;
						rd_row = gl_row + 3'd1;
					end else begin
						aop = AOP_PIX;
					end
				end
			end
			default: begin
				aop = AOP_NOP;
			end
		endcase
	end

	assign rd_wide = {5'b0, glyph_q} << 3 | {9'b0, rd_row};
	assign rd_addr = rd_wide[AW-1:0];

	assign ready      = (state_q == ST_IDLE);
	assign col        = col_q;
	assign pix.emit   = emit;
	assign pix.last   = last;
	assign pix.value  = (font_row[3'd7 - gl_col] && !oob_q) ? PIX_ON : PIX_OFF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && is_char) begin
				if (char_code == CODE_CR) begin
					col_q <= '0;
				end else if (char_code == CODE_LF) begin
					col_q <= '0;
					row_q <= (row_q == ROW_LAST) ? '0 : row_q + RW'(1);
				end
			end
			if (state_q == ST_START) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + PIX_CNT_W'(1);
				if (last) begin
					if (col_q == COL_LAST) begin
						col_q <= '0;
						row_q <= (row_q == ROW_LAST) ? '0 : row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end
		end
	end

	// glyph number and store bound, captured with the character
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && is_char) begin
			glyph_q <= glyph_in;
			oob_q   <= ({1'b0, glyph_in} >= 8'(GLYPH_COUNT));
		end
	end

endmodule

// ===== hdl/bfr_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the bitmap font character renderer, with its bind.
module bfr_chk import bfr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// a stalled transaction holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed under stall");

	// no new item is taken while a character is part way out
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready == m_tready && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of a character");

	// pixels of one character follow with no gap while the receiver takes them
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a character");

	// a font write produces no pixel
	a_font_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_FONT) && !m_tvalid |=> !m_tvalid)
		else $error("pixel after a font write");

endmodule

bind bitmap_font_char_renderer bfr_chk u_bfr_chk (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap font character renderer: table-driven and random text.
module tb;
	import bfr_pkg::*;

	// Geometry, matched to the instance below
	localparam int COLS    = 20;
	localparam int ROWS    = 12;
	localparam int STRIDE  = 160;
	localparam int GLYPHS  = 96;
	localparam int STORE_N = GLYPHS * 8;

	localparam int IDLE_PCT    = 11;    // chance per cycle that a side idles
	localparam int ITEM_TARGET = 250;   // text items that change something
	localparam int TAIL_CYCLES = 100;   // quiet time after the last pixel
	localparam int DEAD_LIMIT  = 2000;  // cycles with no transaction before giving up

	// Character codes besides the ones in the package
	localparam logic [CODE_W-1:0] CODE_NUL      = 8'd0;
	localparam logic [CODE_W-1:0] CODE_LAST_PR  = 8'd127;
	localparam logic [CODE_W-1:0] CODE_HIGH_MIN = 8'd128;
	localparam logic [CODE_W-1:0] CODE_HIGH_MAX = 8'd255;
	localparam logic [CODE_W-1:0] CODE_CTL_MAX  = 8'd31;

	// One text item; typed rows carry their own pixel count and top-left address
	typedef struct packed {
		opcode_t            op;
		logic [FIDX_W-1:0]  idx;
		logic [7:0]         fbyte;
		logic [CODE_W-1:0]  code;
		logic               typed;
		logic [6:0]         t_cnt;
		logic [ADDR_W-1:0]  t_base;
	} text_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  value;
		logic              last;
	} pixel_write_t;

	// Directed table: glyph 0 (space) and glyph 95 (code 127) loaded first, then
	// out-of-range font writes that must not alias into the store, then renders
	// at the corners of the cursor moves, CR, LF, and codes that do nothing.
	localparam int DIR_N = 26;
	localparam text_item_t DIR_TAB [DIR_N] = '{
		'{OP_FONT, 10'd0,    8'h81, CODE_NUL, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd1,    8'hFF, CODE_NUL, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd2,    8'h00, CODE_NUL, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd3,    8'h80, CODE_NUL, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd4,    8'h01, CODE_NUL, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd5,    8'hAA, CODE_NUL, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd6,    8'h55, CODE_NUL, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd7,    8'h3C, CODE_NUL, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd760,  8'h00, CODE_HIGH_MAX, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd761,  8'h7E, CODE_HIGH_MAX, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd762,  8'h42, CODE_HIGH_MAX, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd763,  8'h5A, CODE_HIGH_MAX, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd764,  8'h5A, CODE_HIGH_MAX, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd765,  8'h42, CODE_HIGH_MAX, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd766,  8'h7E, CODE_HIGH_MAX, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd767,  8'hFF, CODE_HIGH_MAX, 1'b1, 7'd0, 14'd0},
		// out of range: ignored
		'{OP_FONT, 10'd768,  8'h7E, CODE_NUL, 1'b1, 7'd0, 14'd0},
		'{OP_FONT, 10'd1023, 8'hC3, CODE_NUL, 1'b1, 7'd0, 14'd0},
		// space at the home position, then code 127 one cell along
		'{OP_CHAR, 10'd0,    8'h00, FIRST_PRINTABLE, 1'b1, 7'd64, 14'd0},
		'{OP_CHAR, 10'd1023, 8'hFF, CODE_LAST_PR,    1'b1, 7'd64, 14'd8},
		// CR back to column 0, space overwrites the home cell
		'{OP_CHAR, 10'd0,    8'h00, CODE_CR,         1'b1, 7'd0,  14'd0},
		'{OP_CHAR, 10'd0,    8'h00, FIRST_PRINTABLE, 1'b1, 7'd64, 14'd0},
		// LF to row 1, column 0
		'{OP_CHAR, 10'd0,    8'h00, CODE_LF,         1'b1, 7'd0,  14'd0},
		'{OP_CHAR, 10'd0,    8'h00, CODE_LAST_PR,    1'b1, 7'd64, 14'd1280},
		// nothing happens for other control codes or high codes
		'{OP_CHAR, 10'd0,    8'h00, CODE_NUL,        1'b1, 7'd0,  14'd0},
		'{OP_CHAR, 10'd0,    8'h00, CODE_HIGH_MAX,   1'b1, 7'd0,  14'd0}
	};

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;  // font_index[9:0], font_byte[17:10], char_code[25:18]
	logic                  s_tuser  = 1'b0;  // opcode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;  // pixel_address[13:0], pixel_value[21:14]
	logic                  m_tlast;  // last_pixel

	// Predicted screen state
	logic [4:0]       cur_col;
	logic [3:0]       cur_row;
	logic [7:0]       font_img [STORE_N];
	bit               font_set [STORE_N];
	pixel_write_t     pending_pixels [$];

	int unsigned text_items;       // items that wrote the store or moved the cursor
	int unsigned mismatches  = 0;
	int unsigned dead_cycles = 0;
	bit          steady;           // no idling on either side while set

	bitmap_font_char_renderer #(
		.COLUMNS     (COLS),
		.ROWS        (ROWS),
		.LINE_STRIDE (STRIDE),
		.GLYPH_COUNT (GLYPHS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Queue the 64 pixel writes of one glyph cell, row by row, MSB leftmost.
	// Addresses wrap at 14 bits as the port does.
	function automatic void plot_glyph(input logic [ADDR_W-1:0] base, input int unsigned glyph);
		pixel_write_t p;
		int unsigned  a;
		logic [7:0]   bits;
		for (int r = 0; r < 8; r++) begin
			bits = font_img[glyph * 8 + r];
			for (int c = 0; c < 8; c++) begin
				a       = int'(base) + STRIDE * r + c;
				p.addr  = a[ADDR_W-1:0];
				p.value = bits[7 - c] ? PIX_ON : PIX_OFF;
				p.last  = (r == 7) && (c == 7);
				pending_pixels.push_back(p);
			end
		end
	endfunction

	// Apply one accepted item to the predicted state. Gives whether a glyph is
	// drawn and where its top-left pixel lands (cursor taken before advancing).
	function automatic void advance_text(input text_item_t it, output bit draws,
			output logic [ADDR_W-1:0] base);
		int unsigned b;
		draws = 1'b0;
		base  = '0;
		if (it.op == OP_FONT) begin
			if (it.idx < STORE_N) begin
				font_img[it.idx] = it.fbyte;
				font_set[it.idx] = 1'b1;
				text_items++;
			end
		end else if (it.code < FIRST_PRINTABLE) begin
			if (it.code == CODE_CR) begin
				cur_col = '0;
				text_items++;
			end else if (it.code == CODE_LF) begin
				cur_col = '0;
				cur_row = (cur_row == ROWS - 1) ? '0 : cur_row + 1'b1;
				text_items++;
			end
		end else if (it.code < CODE_HIGH_MIN) begin
			b     = STRIDE * 8 * cur_row + 8 * cur_col;
			base  = b[ADDR_W-1:0];
			draws = 1'b1;
			text_items++;
			// column wraps first, then the row
			if (cur_col == COLS - 1) begin
				cur_col = '0;
				cur_row = (cur_row == ROWS - 1) ? '0 : cur_row + 1'b1;
			end else begin
				cur_col = cur_col + 1'b1;
			end
		end
	endfunction

	function automatic bit glyph_ready(input int unsigned g);
		for (int r = 0; r < 8; r++)
			if (!font_set[g * 8 + r])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic text_item_t mk_item(input opcode_t op, input int unsigned idx,
			input int unsigned fbyte, input int unsigned code);
		text_item_t it;
		it        = '0;
		it.op     = op;
		it.idx    = idx[FIDX_W-1:0];
		it.fbyte  = fbyte[7:0];
		it.code   = code[CODE_W-1:0];
		return it;
	endfunction

	// Present one item, hold it until the transaction, then predict.
	// tvalid is only lowered while idling, so back-to-back items never see a
	// low and a high in the same time step.
	task automatic send_item(input text_item_t it);
		bit                draws;
		logic [ADDR_W-1:0] base;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {6'd0, it.code, it.fbyte, it.idx};
		do @(posedge clk); while (!s_tready);
		advance_text(it, draws, base);
		if (it.typed) begin
			if (it.t_cnt != 0)
				plot_glyph(it.t_base, int'(it.code) - int'(FIRST_PRINTABLE));
		end else if (draws) begin
			plot_glyph(base, int'(it.code) - int'(FIRST_PRINTABLE));
		end
	endtask

	// Sender holds off until every queued pixel has come out
	task automatic drain_pixels();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	// Pixel checker, receiver stalls and the no-progress counter
	always @(posedge clk) begin
		pixel_write_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel transaction with nothing expected: address %0d", m_tdata[13:0]);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata[13:0] !== want.addr) begin
					$error("pixel_address: expected %0d, got %0d", want.addr, m_tdata[13:0]);
					mismatches++;
				end
				if (m_tdata[21:14] !== want.value) begin
					$error("pixel_value: expected %0d, got %0d", want.value, m_tdata[21:14]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last_pixel: expected %0d, got %0d", want.last, m_tlast);
					mismatches++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			dead_cycles <= 0;
		else
			dead_cycles <= dead_cycles + 1;
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// Watchdog: a correct run never goes this long without a transaction
	initial begin
		while (dead_cycles < DEAD_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int unsigned pick;
		int unsigned g;
		int unsigned n;
		bit          mid_pause;
		cur_col     = '0;
		cur_row     = '0;
		text_items  = 0;
		steady      = 1'b0;
		mid_pause   = 1'b0;
		for (int i = 0; i < STORE_N; i++) begin
			font_img[i] = '0;
			font_set[i] = 1'b0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_item(DIR_TAB[i]);
		drain_pixels();

		// Random text: glyph loads, runs of printable characters ended now and
		// then by CR or LF, stray font writes, and codes that do nothing.
		// Only glyphs with all eight rows written are ever drawn.
		while (text_items < ITEM_TARGET) begin
			steady = (text_items >= 100) && (text_items < 150);
			if (!mid_pause && text_items >= ITEM_TARGET / 2) begin
				drain_pixels();
				mid_pause = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 12) begin
				g = $urandom_range(GLYPHS - 1);
				for (int r = 0; r < 8; r++)
					send_item(mk_item(OP_FONT, g * 8 + r, $urandom_range(255),
						$urandom_range(255)));
			end else if (pick < 65) begin
				// runs up to 25 long so the column wraps on its own
				n = $urandom_range(25, 1);
				repeat (n) begin
					do g = $urandom_range(GLYPHS - 1); while (!glyph_ready(g));
					send_item(mk_item(OP_CHAR, $urandom_range(1023), $urandom_range(255),
						FIRST_PRINTABLE + g));
				end
				case ($urandom_range(3))
					0: begin
						send_item(mk_item(OP_CHAR, $urandom_range(1023), $urandom_range(255),
							CODE_CR));
					end
					1: begin
						send_item(mk_item(OP_CHAR, $urandom_range(1023), $urandom_range(255),
							CODE_LF));
					end
					default: begin
					end
				endcase
			end else if (pick < 80) begin
				// anywhere in the index range, out-of-range ones included
				send_item(mk_item(OP_FONT, $urandom_range(1023), $urandom_range(255),
					$urandom_range(255)));
			end else begin
				if ($urandom_range(1))
					n = $urandom_range(CODE_CTL_MAX);
				else
					n = $urandom_range(CODE_HIGH_MAX, CODE_HIGH_MIN);
				send_item(mk_item(OP_CHAR, $urandom_range(1023), $urandom_range(255), n));
			end
		end
		steady = 1'b0;

		drain_pixels();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
